// File: hdl/great_circle_distance_with_altitude_unit_macros.svh
// ----------------------------------------------------------------------------
// great_circle_distance_with_altitude_unit_macros
// assertion macros for the distance unit, clocked on clk, reset by rst
// ----------------------------------------------------------------------------
`ifndef GREAT_CIRCLE_DISTANCE_WITH_ALTITUDE_UNIT_MACROS_SVH
`define GREAT_CIRCLE_DISTANCE_WITH_ALTITUDE_UNIT_MACROS_SVH

// same-cycle implication, off during reset
`define GCDWA_ASSERT_IMP(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("distance unit check failed");

// next-cycle implication, off during reset
`define GCDWA_ASSERT_NXT(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("distance unit check failed");

// next-cycle implication, also live in reset
`define GCDWA_ASSERT_RST(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) (cond) |=> (prop)) \
    else $error("distance unit reset check failed");

`endif

// File: hdl/gcdwa_pkg.sv
// ----------------------------------------------------------------------------
// gcdwa_pkg
// constants, stage map and arctangent table of the distance unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gcdwa_pkg;

  localparam int CORDIC_STEPS = 30;
  localparam int SQRT_STEPS   = 31;

  localparam int ROT_W = 34;
  localparam int VEC_W = 36;
  localparam int VZ_W  = 35;
  localparam int HYP_W = 46;
  localparam int SQ_W  = 62;

  // stage map
  localparam int ROT_FIRST  = 5;
  localparam int MUL_FIRST  = ROT_FIRST + CORDIC_STEPS;
  localparam int ACOS_PREP  = MUL_FIRST + 4;
  localparam int SQRT_FIRST = ACOS_PREP + 1;
  localparam int VEC_FIRST  = SQRT_FIRST + SQRT_STEPS;
  localparam int SURF_FIRST = VEC_FIRST + CORDIC_STEPS;
  localparam int HYP_FIRST  = SURF_FIRST + 3;
  localparam int OUT_FIRST  = HYP_FIRST + CORDIC_STEPS;
  localparam int PIPE_DEPTH = OUT_FIRST + 3;

  localparam logic signed [34:0] ONE_Q30     = 35'sd1073741824;
  localparam logic signed [35:0] PI_Q30      = 36'sd3373259426;
  localparam logic [31:0]        PI_U        = 32'd3373259426;
  localparam logic [31:0]        HALF_PI_U   = 32'd1686629713;
  localparam logic [32:0]        DEG7_TO_RAD = 33'd8048910509;
  localparam logic [32:0]        EARTH_MM    = 33'd6372795478;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic [29:0]        GAIN_U      = 30'd652032874;
  localparam logic signed [30:0] LAT_LIMIT   = 31'sd900000000;
  localparam logic signed [34:0] FULL_TURN   = 35'sd3600000000;
  localparam logic signed [34:0] FULL_TURN2  = 35'sd7200000000;
  localparam logic [31:0]        FULL_TURN_U = 32'd3600000000;
  localparam logic [31:0]        HALF_TURN_U = 32'd1800000000;
  localparam logic [34:0]        DIST_MAX    = 35'h7FFFFFFFF;

  function automatic logic [29:0] atan_q30(input int unsigned idx);
    logic [29:0] v;
    case (idx)
      0:  v = 30'd843314857;
      1:  v = 30'd497837829;
      2:  v = 30'd263043837;
      3:  v = 30'd133525159;
      4:  v = 30'd67021687;
      5:  v = 30'd33543516;
      6:  v = 30'd16775851;
      7:  v = 30'd8388437;
      8:  v = 30'd4194283;
      9:  v = 30'd2097149;
      10: v = 30'd1048576;
      11: v = 30'd524288;
      12: v = 30'd262144;
      13: v = 30'd131072;
      14: v = 30'd65536;
      15: v = 30'd32768;
      16: v = 30'd16384;
      17: v = 30'd8192;
      18: v = 30'd4096;
      19: v = 30'd2048;
      20: v = 30'd1024;
      21: v = 30'd512;
      22: v = 30'd256;
      23: v = 30'd128;
      24: v = 30'd64;
      25: v = 30'd32;
      26: v = 30'd16;
      27: v = 30'd8;
      28: v = 30'd4;
      29: v = 30'd2;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// File: hdl/great_circle_distance_with_altitude_unit.sv
// ----------------------------------------------------------------------------
// great_circle_distance_with_altitude_unit
// distance between two positions over the earth surface and in altitude
// ----------------------------------------------------------------------------
// A request is taken at a rising edge with start high and busy low; the six
// position fields are sampled there. busy is high for the first cycle after
// reset and low from then on, so a request can be issued every cycle.
// Each result appears on distance_mm for exactly one cycle with done high,
// in request order. Throughput is one request per cycle: every CORDIC
// iteration, root step and partial product has a register stage of its own,
// the longest path is one 32x32 multiply or one 62-bit compare and subtract.
// The receiver cannot stall the unit; results must be taken as they come.
// Reset clears the valid line, so requests in flight are dropped and no
// done pulse appears until a new request has gone through.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "great_circle_distance_with_altitude_unit_macros.svh"

module great_circle_distance_with_altitude_unit
  import gcdwa_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [30:0] lat_first,
  input  logic signed [31:0] lon_first,
  input  logic signed [27:0] alt_first,
  input  logic signed [30:0] lat_second,
  input  logic signed [31:0] lon_second,
  input  logic signed [27:0] alt_second,
  output logic               busy,
  output logic               done,
  output logic [34:0]        distance_mm
);

  logic vld [PIPE_DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
      for (int k = 0; k < PIPE_DEPTH; k++) begin
        vld[k] <= 1'b0;
      end
    end else begin
      busy   <= 1'b0;
      vld[0] <= start & ~busy;
      for (int k = 1; k < PIPE_DEPTH; k++) begin
        vld[k] <= vld[k-1];
      end
    end
  end

  assign done = vld[PIPE_DEPTH-1];

  // input stage: clamp latitudes, longitude and altitude differences
  logic signed [30:0] lat1_cl, lat2_cl, a_lat1, a_lat2;
  logic signed [32:0] dlon_raw, a_dl;
  logic signed [28:0] dalt;
  logic [28:0]        dh_abs;
  logic [28:0]        dh_pipe [HYP_FIRST];

  always_comb begin
    if (lat_first > LAT_LIMIT) lat1_cl = LAT_LIMIT;
    else if (lat_first < -LAT_LIMIT) lat1_cl = -LAT_LIMIT;
    else lat1_cl = lat_first;
    if (lat_second > LAT_LIMIT) lat2_cl = LAT_LIMIT;
    else if (lat_second < -LAT_LIMIT) lat2_cl = -LAT_LIMIT;
    else lat2_cl = lat_second;
    dlon_raw = {lon_first[31], lon_first} - {lon_second[31], lon_second};
    dalt     = {alt_first[27], alt_first} - {alt_second[27], alt_second};
    dh_abs   = dalt[28] ? 29'(-dalt) : 29'(dalt);
  end

  always_ff @(posedge clk) begin
    a_lat1     <= lat1_cl;
    a_lat2     <= lat2_cl;
    a_dl       <= dlon_raw;
    dh_pipe[0] <= dh_abs;
  end

  for (genvar j = 1; j < HYP_FIRST; j++) begin : g_dh
    always_ff @(posedge clk) begin
      dh_pipe[j] <= dh_pipe[j-1];
    end
  end

  // longitude difference wrapped onto one turn
  logic signed [34:0] dlx, dln;
  logic signed [30:0] b_lat1, b_lat2;
  logic [31:0]        b_dl;

  always_comb begin
    dlx = {{2{a_dl[32]}}, a_dl};
    if (dlx < -FULL_TURN) dln = dlx + FULL_TURN2;
    else if (dlx < 0) dln = dlx + FULL_TURN;
    else if (dlx >= FULL_TURN) dln = dlx - FULL_TURN;
    else dln = dlx;
  end

  always_ff @(posedge clk) begin
    b_lat1 <= a_lat1;
    b_lat2 <= a_lat2;
    b_dl   <= dln[31:0];
  end

  // fold onto half a turn, split latitude sign and magnitude
  logic [31:0] c_dl;
  logic [30:0] c_m1, c_m2;
  logic        c_n1, c_n2;

  always_ff @(posedge clk) begin
    c_dl <= (b_dl > HALF_TURN_U) ? FULL_TURN_U - b_dl : b_dl;
    c_n1 <= b_lat1[30];
    c_n2 <= b_lat2[30];
    c_m1 <= b_lat1[30] ? 31'(-b_lat1) : 31'(b_lat1);
    c_m2 <= b_lat2[30] ? 31'(-b_lat2) : 31'(b_lat2);
  end

  // degrees to radians
  logic [64:0]        pr1, pr2, prf;
  logic signed [31:0] rs1, rs2, d_lat1, d_lat2;
  logic [31:0]        d_fa;

  always_comb begin
    pr1 = 65'(c_m1) * 65'(DEG7_TO_RAD) + (65'd1 << 31);
    pr2 = 65'(c_m2) * 65'(DEG7_TO_RAD) + (65'd1 << 31);
    prf = 65'(c_dl) * 65'(DEG7_TO_RAD) + (65'd1 << 31);
    rs1 = $signed({1'b0, pr1[62:32]});
    rs2 = $signed({1'b0, pr2[62:32]});
  end

  always_ff @(posedge clk) begin
    d_lat1 <= c_n1 ? -rs1 : rs1;
    d_lat2 <= c_n2 ? -rs2 : rs2;
    d_fa   <= prf[63:32];
  end

  // rotation inputs, longitude angle reflected past a quarter turn
  logic signed [ROT_W-1:0] rot_z0 [3];
  logic                    rot_neg0;

  always_ff @(posedge clk) begin
    rot_z0[0] <= {{2{d_lat1[31]}}, d_lat1};
    rot_z0[1] <= {{2{d_lat2[31]}}, d_lat2};
    if (d_fa > HALF_PI_U) begin
      rot_z0[2] <= $signed({2'b00, PI_U - d_fa});
      rot_neg0  <= 1'b1;
    end else begin
      rot_z0[2] <= $signed({2'b00, d_fa});
      rot_neg0  <= 1'b0;
    end
  end

  // sine and cosine, three lanes of rotation cordic
  logic signed [ROT_W-1:0] rot_x [CORDIC_STEPS][3];
  logic signed [ROT_W-1:0] rot_y [CORDIC_STEPS][3];
  logic signed [ROT_W-1:0] rot_z [CORDIC_STEPS][3];
  logic                    rot_neg [CORDIC_STEPS];

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
    logic signed [ROT_W-1:0] xin [3];
    logic signed [ROT_W-1:0] yin [3];
    logic signed [ROT_W-1:0] zin [3];
    logic signed [ROT_W-1:0] xn [3];
    logic signed [ROT_W-1:0] yn [3];
    logic signed [ROT_W-1:0] zn [3];
    logic signed [ROT_W-1:0] at;
    logic                    negin;

    if (i == 0) begin : g_in
      always_comb begin
        for (int l = 0; l < 3; l++) begin
          xin[l] = CORDIC_GAIN;
          yin[l] = '0;
          zin[l] = rot_z0[l];
        end
        negin = rot_neg0;
      end
    end else begin : g_in
      always_comb begin
        for (int l = 0; l < 3; l++) begin
          xin[l] = rot_x[i-1][l];
          yin[l] = rot_y[i-1][l];
          zin[l] = rot_z[i-1][l];
        end
        negin = rot_neg[i-1];
      end
    end

    always_comb begin
      at = $signed({4'b0000, atan_q30(i)});
      for (int l = 0; l < 3; l++) begin
        if (zin[l] >= 0) begin
          xn[l] = xin[l] - (yin[l] >>> i);
          yn[l] = yin[l] + (xin[l] >>> i);
          zn[l] = zin[l] - at;
        end else begin
          xn[l] = xin[l] + (yin[l] >>> i);
          yn[l] = yin[l] - (xin[l] >>> i);
          zn[l] = zin[l] + at;
        end
      end
    end

    always_ff @(posedge clk) begin
      for (int l = 0; l < 3; l++) begin
        rot_x[i][l] <= xn[l];
        rot_y[i][l] <= yn[l];
        rot_z[i][l] <= zn[l];
      end
      rot_neg[i] <= negin;
    end
  end

  // cosine of the central angle
  logic signed [63:0] f_pss, f_pcc, f_p3, pss_r, pcc_r, p3_r;
  logic signed [31:0] f_cf, f2_cf, cf_raw;
  logic signed [33:0] f_rss, f_rcc, f3_rss;
  logic signed [34:0] p3s, csum;
  logic signed [31:0] c_q30;

  always_comb begin
    cf_raw = $signed(rot_x[CORDIC_STEPS-1][2][31:0]);
    pss_r  = (f_pss + 64'sd536870912) >>> 30;
    pcc_r  = (f_pcc + 64'sd536870912) >>> 30;
    p3_r   = (f_p3 + 64'sd536870912) >>> 30;
    p3s    = p3_r[34:0];
    csum   = {f3_rss[33], f3_rss} + p3s;
  end

  always_ff @(posedge clk) begin
    f_pss  <= $signed(rot_y[CORDIC_STEPS-1][0][31:0])
            * $signed(rot_y[CORDIC_STEPS-1][1][31:0]);
    f_pcc  <= $signed(rot_x[CORDIC_STEPS-1][0][31:0])
            * $signed(rot_x[CORDIC_STEPS-1][1][31:0]);
    f_cf   <= rot_neg[CORDIC_STEPS-1] ? -cf_raw : cf_raw;
    f_rss  <= pss_r[33:0];
    f_rcc  <= pcc_r[33:0];
    f2_cf  <= f_cf;
    f_p3   <= $signed(f_rcc[31:0]) * f2_cf;
    f3_rss <= f_rss;
    if (csum > ONE_Q30) c_q30 <= 32'(ONE_Q30);
    else if (csum < -ONE_Q30) c_q30 <= 32'(-ONE_Q30);
    else c_q30 <= csum[31:0];
  end

  // acos set-up: (1 - c)(1 + c)
  logic signed [34:0] om_c, op_c;
  logic [SQ_W-1:0]    g_sq;
  logic [30:0]        g_xabs;
  logic               g_cneg;
  logic [63:0]        sq_full;

  always_comb begin
    om_c    = ONE_Q30 - {{3{c_q30[31]}}, c_q30};
    op_c    = ONE_Q30 + {{3{c_q30[31]}}, c_q30};
    sq_full = 64'(om_c[31:0]) * 64'(op_c[31:0]);
  end

  always_ff @(posedge clk) begin
    g_sq   <= sq_full[SQ_W-1:0];
    g_xabs <= c_q30[31] ? 31'(-c_q30) : 31'(c_q30);
    g_cneg <= c_q30[31];
  end

  // integer square root, one result bit a stage
  logic [SQ_W-1:0] sq_v [SQRT_STEPS];
  logic [SQ_W-1:0] sq_r [SQRT_STEPS];
  logic [30:0]     sq_xa [SQRT_STEPS];
  logic            sq_cn [SQRT_STEPS];

  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
    localparam logic [SQ_W-1:0] SQ_BIT = SQ_W'(1) << (2 * (SQRT_STEPS - 1 - i));
    logic [SQ_W-1:0] vin, rin, tr;
    logic [30:0]     xain;
    logic            cnin;

    if (i == 0) begin : g_in
      assign vin  = g_sq;
      assign rin  = '0;
      assign xain = g_xabs;
      assign cnin = g_cneg;
    end else begin : g_in
      assign vin  = sq_v[i-1];
      assign rin  = sq_r[i-1];
      assign xain = sq_xa[i-1];
      assign cnin = sq_cn[i-1];
    end

    assign tr = rin + SQ_BIT;

    always_ff @(posedge clk) begin
      if (vin >= tr) begin
        sq_v[i] <= vin - tr;
        sq_r[i] <= (rin >> 1) + SQ_BIT;
      end else begin
        sq_v[i] <= vin;
        sq_r[i] <= rin >> 1;
      end
      sq_xa[i] <= xain;
      sq_cn[i] <= cnin;
    end
  end

  // angle from vectoring cordic on (|c|, root)
  logic signed [VEC_W-1:0] vec_x [CORDIC_STEPS];
  logic signed [VEC_W-1:0] vec_y [CORDIC_STEPS];
  logic signed [VZ_W-1:0]  vec_z [CORDIC_STEPS];
  logic                    vec_cn [CORDIC_STEPS];

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_vec
    logic signed [VEC_W-1:0] xin, yin;
    logic signed [VZ_W-1:0]  zin, at;
    logic                    cnin;

    if (i == 0) begin : g_in
      assign xin  = $signed({5'b00000, sq_xa[SQRT_STEPS-1]});
      assign yin  = $signed({5'b00000, sq_r[SQRT_STEPS-1][30:0]});
      assign zin  = '0;
      assign cnin = sq_cn[SQRT_STEPS-1];
    end else begin : g_in
      assign xin  = vec_x[i-1];
      assign yin  = vec_y[i-1];
      assign zin  = vec_z[i-1];
      assign cnin = vec_cn[i-1];
    end

    assign at = $signed({5'b00000, atan_q30(i)});

    always_ff @(posedge clk) begin
      if (yin >= 0) begin
        vec_x[i] <= xin + (yin >>> i);
        vec_y[i] <= yin - (xin >>> i);
        vec_z[i] <= zin + at;
      end else begin
        vec_x[i] <= xin - (yin >>> i);
        vec_y[i] <= yin + (xin >>> i);
        vec_z[i] <= zin - at;
      end
      vec_cn[i] <= cnin;
    end
  end

  // central angle to surface distance
  logic signed [35:0] zfull, aang;
  logic [31:0]        j_ang;
  logic [48:0]        j_pt, j_pu;
  logic [65:0]        surf_sum;
  logic [34:0]        surf;

  always_comb begin
    zfull    = {vec_z[CORDIC_STEPS-1][VZ_W-1], vec_z[CORDIC_STEPS-1]};
    aang     = vec_cn[CORDIC_STEPS-1] ? PI_Q30 - zfull : zfull;
    surf_sum = {1'b0, j_pt, 16'h0000} + 66'(j_pu) + (66'd1 << 29);
  end

  always_ff @(posedge clk) begin
    if (aang < 0) j_ang <= '0;
    else if (aang > PI_Q30) j_ang <= PI_U;
    else j_ang <= aang[31:0];
    j_pt <= 49'(j_ang[31:16]) * 49'(EARTH_MM);
    j_pu <= 49'(j_ang[15:0]) * 49'(EARTH_MM);
    surf <= surf_sum[64:30];
  end

  // hypotenuse of surface distance and altitude difference
  logic signed [HYP_W-1:0] hyp_x [CORDIC_STEPS];
  logic signed [HYP_W-1:0] hyp_y [CORDIC_STEPS];

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_hyp
    logic signed [HYP_W-1:0] xin, yin;

    if (i == 0) begin : g_in
      assign xin = $signed({3'b000, surf, 8'h00});
      assign yin = $signed({9'h000, dh_pipe[HYP_FIRST-1], 8'h00});
    end else begin : g_in
      assign xin = hyp_x[i-1];
      assign yin = hyp_y[i-1];
    end

    always_ff @(posedge clk) begin
      if (yin >= 0) begin
        hyp_x[i] <= xin + (yin >>> i);
        hyp_y[i] <= yin - (xin >>> i);
      end else begin
        hyp_x[i] <= xin - (yin >>> i);
        hyp_y[i] <= yin + (xin >>> i);
      end
    end
  end

  // gain correction and rounding to the millimetre
  logic [44:0] xc;
  logic [52:0] o_ph;
  logic [51:0] o_pl;
  logic [75:0] gsum;
  logic [45:0] o_v;
  logic [46:0] rnd;

  always_comb begin
    xc   = hyp_x[CORDIC_STEPS-1][HYP_W-1] ? '0 : hyp_x[CORDIC_STEPS-1][44:0];
    gsum = {1'b0, o_ph, 22'h000000} + 76'(o_pl) + (76'd1 << 29);
    rnd  = 47'(o_v) + 47'd128;
  end

  always_ff @(posedge clk) begin
    o_ph <= 53'(xc[44:22]) * 53'(GAIN_U);
    o_pl <= 52'(xc[21:0]) * 52'(GAIN_U);
    o_v  <= gsum[75:30];
    if (rnd[46:8] > 39'(DIST_MAX)) distance_mm <= DIST_MAX;
    else distance_mm <= rnd[42:8];
  end

  `GCDWA_ASSERT_RST(a_reset_quiet, rst, !done && busy)
  `GCDWA_ASSERT_IMP(a_cos_range, vld[ACOS_PREP-1], (c_q30 <= 32'sd1073741824) && (c_q30 >= -32'sd1073741824))
  `GCDWA_ASSERT_IMP(a_root_range, vld[VEC_FIRST-1], sq_r[SQRT_STEPS-1] <= 62'd1073741824)
  `GCDWA_ASSERT_NXT(a_angle_range, vld[SURF_FIRST-1], j_ang <= PI_U)

endmodule

`default_nettype wire

// File: test/great_circle_distance_with_altitude_unit_checker.sv
// ----------------------------------------------------------------------------
// great_circle_distance_with_altitude_unit_checker
// Watches the request and result channels of the distance unit. For every
// accepted request it computes the expected distance in bit-exact fixed point.
// Each done pulse is compared with the oldest expected distance.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module great_circle_distance_with_altitude_unit_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic signed [30:0] lat_first,
  input  logic signed [31:0] lon_first,
  input  logic signed [27:0] alt_first,
  input  logic signed [30:0] lat_second,
  input  logic signed [31:0] lon_second,
  input  logic signed [27:0] alt_second,
  input  logic               done,
  input  logic [34:0]        distance_mm,
  output int                 fail_count,
  output int                 pending
);

  localparam longint ONE       = 64'sd1073741824;
  localparam longint HALF_PI   = 64'sd1686629713;
  localparam longint PI        = 64'sd3373259426;
  localparam longint GAIN      = 64'sd652032874;
  localparam longint DEG_SCALE = 64'sd8048910509;
  localparam longint RADIUS_MM = 64'sd6372795478;
  localparam longint LAT_MAX   = 64'sd900000000;
  localparam longint TURN      = 64'sd3600000000;
  localparam longint HALF_TURN = 64'sd1800000000;
  localparam longint DIST_TOP  = 64'sd34359738367;

  logic [34:0] distance_q[$];

  function automatic longint arctan_step(int i);
    longint tbl[30] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                        33543516, 16775851, 8388437, 4194283, 2097149, 1048576,
                        524288, 262144, 131072, 65536, 32768, 16384, 8192, 4096,
                        2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2};
    return tbl[i];
  endfunction

  function automatic longint round_frac(longint p);
    return (p + (64'sd1 << 29)) >>> 30;
  endfunction

  function automatic longint scale_frac(longint a, longint b);
    logic [127:0] p;
    p = 128'(a) * 128'(b) + (128'd1 << 29);
    return longint'(p >> 30);
  endfunction

  function automatic longint to_radians(longint d);
    logic [127:0] m;
    longint r;
    m = (d < 0) ? 128'(-d) : 128'(d);
    r = longint'((m * 128'(DEG_SCALE) + (128'd1 << 31)) >> 32);
    return (d < 0) ? -r : r;
  endfunction

  function automatic void rotate(longint ang, output longint s, output longint c);
    longint x, y, z, dx, dy;
    x = GAIN; y = 0; z = ang;
    for (int i = 0; i < 30; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= arctan_step(i);
      end else begin
        x += dx; y -= dy; z += arctan_step(i);
      end
    end
    s = y;
    c = x;
  endfunction

  function automatic longint int_root(longint v);
    longint res, b;
    res = 0;
    b = 64'sd1 << 62;
    while (b > v) b = b >>> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >>> 1) + b;
      end else begin
        res = res >>> 1;
      end
      b = b >>> 2;
    end
    return res;
  endfunction

  function automatic longint central_angle(longint c);
    longint x, y, z, dx, dy, a;
    x = (c < 0) ? -c : c;
    y = int_root((ONE - c) * (ONE + c));
    z = 0;
    for (int i = 0; i < 30; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += arctan_step(i);
      end else begin
        x -= dx; y += dy; z -= arctan_step(i);
      end
    end
    a = (c < 0) ? PI - z : z;
    if (a < 0) a = 0;
    if (a > PI) a = PI;
    return a;
  endfunction

  function automatic longint hypotenuse_mm(longint s, longint h);
    longint x, y, dx, dy;
    x = s <<< 8;
    y = h <<< 8;
    for (int i = 0; i < 30; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy;
      end else begin
        x -= dx; y += dy;
      end
    end
    if (x < 0) x = 0;
    return (scale_frac(x, GAIN) + 128) >>> 8;
  endfunction

  function automatic logic [34:0] predict_distance(longint lat1, longint lon1,
                                                   longint alt1, longint lat2,
                                                   longint lon2, longint alt2);
    longint dl, fa, sa, ca, sb, cb, sf, cf, c, surf, dh, d;
    if (lat1 > LAT_MAX) lat1 = LAT_MAX;
    if (lat1 < -LAT_MAX) lat1 = -LAT_MAX;
    if (lat2 > LAT_MAX) lat2 = LAT_MAX;
    if (lat2 < -LAT_MAX) lat2 = -LAT_MAX;
    dl = (lon1 - lon2) % TURN;
    if (dl < 0) dl += TURN;
    if (dl > HALF_TURN) dl = TURN - dl;
    rotate(to_radians(lat1), sa, ca);
    rotate(to_radians(lat2), sb, cb);
    fa = to_radians(dl);
    if (fa > HALF_PI) begin
      rotate(PI - fa, sf, cf);
      cf = -cf;
    end else begin
      rotate(fa, sf, cf);
    end
    c = round_frac(sa * sb) + round_frac(round_frac(ca * cb) * cf);
    if (c > ONE) c = ONE;
    if (c < -ONE) c = -ONE;
    surf = scale_frac(central_angle(c), RADIUS_MM);
    dh = alt1 - alt2;
    if (dh < 0) dh = -dh;
    d = hypotenuse_mm(surf, dh);
    if (d > DIST_TOP) d = DIST_TOP;
    return d[34:0];
  endfunction

  assign pending = distance_q.size();

  initial fail_count = 0;

  always @(posedge clk) begin
    logic [34:0] want;
    if (!rst) begin
      if (start && !busy)
        distance_q.push_back(predict_distance(lat_first, lon_first, alt_first,
                                              lat_second, lon_second, alt_second));
      if (done) begin
        if (distance_q.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("unexpected result %0d", distance_mm);
        end else begin
          want = distance_q.pop_front();
          if (want !== distance_mm) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("distance mismatch: expected %0d actual %0d", want, distance_mm);
          end
        end
      end
    end
  end

endmodule

// File: test/great_circle_distance_with_altitude_unit_tb.sv
// ----------------------------------------------------------------------------
// great_circle_distance_with_altitude_unit_tb
// Drives position pairs into the distance unit: first directed corner cases,
// then random requests with random gaps. The checker instance predicts and
// compares; this module only gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module great_circle_distance_with_altitude_unit_tb;

  logic               clk = 0;
  logic               rst = 1;
  logic               start = 0;
  logic signed [30:0] lat_first = '0;
  logic signed [31:0] lon_first = '0;
  logic signed [27:0] alt_first = '0;
  logic signed [30:0] lat_second = '0;
  logic signed [31:0] lon_second = '0;
  logic signed [27:0] alt_second = '0;
  logic               busy;
  logic               done;
  logic [34:0]        distance_mm;
  int                 fail_count;
  int                 pending;
  int                 cycles = 0;

  always #5 clk = ~clk;

  great_circle_distance_with_altitude_unit dut (.*);

  great_circle_distance_with_altitude_unit_checker chk (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send_request(longint la1, longint lo1, longint al1,
                              longint la2, longint lo2, longint al2);
    start      <= 1'b1;
    lat_first  <= la1[30:0];
    lon_first  <= lo1[31:0];
    alt_first  <= al1[27:0];
    lat_second <= la2[30:0];
    lon_second <= lo2[31:0];
    alt_second <= al2[27:0];
    do @(posedge clk); while (busy);
  endtask

  task automatic idle_gap();
    int r, n;
    r = $urandom_range(0, 99);
    n = (r < 50) ? 0 : (r < 92) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  function automatic longint raw_bits(int w);
    logic [31:0] v;
    v = $urandom;
    return longint'(signed'(v << (32 - w))) >>> (32 - w);
  endfunction

  initial begin
    longint la1, lo1, al1, la2, lo2, al2;
    int mode;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_request(0, 0, 0, 0, 0, 0);
    send_request(123456789, -987654321, 5000, 123456789, -987654321, 5000);
    send_request(900000000, 0, 0, -900000000, 0, 0);
    send_request(1073741823, 5, 0, -1073741824, 17, 0);
    send_request(-900000001, 0, 0, 900000001, 1800000000, 0);
    send_request(0, 0, 0, 0, 1800000000, 0);
    send_request(0, -2147483648, 0, 0, 2147483647, 0);
    send_request(0, 2147483647, 0, 0, -2147483648, 0);
    send_request(0, 1800000000, 0, 0, -1800000000, 0);
    send_request(0, 0, 134217727, 0, 0, -134217728);
    send_request(0, 0, -134217728, 0, 0, 134217727);
    send_request(0, 900000000, 0, 0, 0, 0);
    send_request(0, 900000001, 0, 0, 0, 0);
    send_request(0, 0, 0, 1, 1, 1);
    send_request(450000000, 1799999999, 100000000, -450000000, 0, -100000000);
    send_request(-1073741824, -2147483648, -134217728,
                 1073741823, 2147483647, 134217727);
    send_request(1, 3599999999 - 4294967296, 0, -1, 0, 0);
    send_request(899999999, 100, 7, 899999999, 1800000100, 7);
    start <= 1'b0;
    wait (pending == 0);
    @(posedge clk);

    for (int i = 0; i < 1950; i++) begin
      mode = $urandom_range(0, 3);
      al1 = raw_bits(28);
      al2 = ($urandom_range(0, 3) == 0) ? al1 : raw_bits(28);
      if (mode == 0) begin
        la1 = raw_bits(31); lo1 = raw_bits(32);
        la2 = raw_bits(31); lo2 = raw_bits(32);
      end else begin
        la1 = longint'($urandom_range(0, 1800000000)) - 900000000;
        lo1 = longint'($urandom_range(0, 3600000000)) - 1800000000;
        if (mode == 1) begin
          la2 = longint'($urandom_range(0, 1800000000)) - 900000000;
          lo2 = longint'($urandom_range(0, 3600000000)) - 1800000000;
        end else if (mode == 2) begin
          la2 = la1 + longint'($urandom_range(0, 20000)) - 10000;
          lo2 = lo1 + longint'($urandom_range(0, 20000)) - 10000;
        end else begin
          la2 = -la1 + longint'($urandom_range(0, 2000)) - 1000;
          lo2 = lo1 + 1800000000 + longint'($urandom_range(0, 2000)) - 1000;
          if (lo2 > 2147483647) lo2 -= 3600000000;
        end
      end
      send_request(la1, lo1, al1, la2, lo2, al2);
      if (i == 900) begin
        start <= 1'b0;
        wait (pending == 0);
        @(posedge clk);
      end else begin
        idle_gap();
      end
    end
    start <= 1'b0;
    wait (pending == 0);
    repeat (150) @(posedge clk);
    if (fail_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

// File: sim.f
+incdir+hdl
hdl/gcdwa_pkg.sv
hdl/great_circle_distance_with_altitude_unit.sv
test/great_circle_distance_with_altitude_unit_checker.sv
test/great_circle_distance_with_altitude_unit_tb.sv
